>>> rtl/olid_pkg.sv
// Shared types and codes for the ordered list block.
// No dependencies; used by olid_cell and ordered_list_insert_delete.
`timescale 1ns / 1ps

package olid_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BEYOND  = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Broadcast to every cell; the enables are already qualified by success.
   typedef struct packed {
      logic               append_en;
      logic               insert_en;
      logic               delete_en;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

>>> rtl/olid_cell.sv
// One list slot: holds an entry and shifts toward either neighbor.
// Depends on olid_pkg for the command struct.
`timescale 1ns / 1ps

module olid_cell #(
   parameter int CMP_W = 6,
   parameter int IDX   = 0
) (
   input  logic                             clock,
   input  olid_pkg::cell_cmd_type           cmd,
   input  logic [CMP_W-1:0]                 count_i,
   input  logic [CMP_W-1:0]                 at_i,
   input  logic [olid_pkg::VALUE_W-1:0]     left_i,
   input  logic [olid_pkg::VALUE_W-1:0]     right_i,
   input  logic                             found_i,
   output logic                             found_o,
   output logic [olid_pkg::VALUE_W-1:0]     entry_o
);

   localparam logic [CMP_W-1:0] HERE = CMP_W'(IDX);

   logic [olid_pkg::VALUE_W-1:0] entry_ff;
   logic [olid_pkg::VALUE_W-1:0] entry_in;
   logic                         match;

   // first-match search ripples from the head through the row
   assign match   = (HERE < count_i) && (entry_ff == cmd.value);
   assign found_o = found_i | match;
   assign entry_o = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.append_en && (HERE == count_i)) begin
         entry_in = cmd.value;
      end
      if (cmd.insert_en) begin
         if (HERE == at_i) begin
            entry_in = cmd.value;
         end else if ((HERE > at_i) && (HERE <= count_i)) begin
            entry_in = left_i;
         end
      end
      if (cmd.delete_en && (found_i || match)) begin
         entry_in = right_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/ordered_list_insert_delete.sv
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// Depends on olid_pkg and olid_cell.
`timescale 1ns / 1ps

// Usage:
//   req_* carries one transaction per item: mode in req_tuser, value and
//   position in req_tdata. Append adds at the tail, insert places at a
//   1-based position (0 or 1 is the head), delete removes the first equal
//   entry, read returns the entry at a position.
//   rsp_* returns exactly one transaction per item: status in rsp_tuser,
//   entry count and read value in rsp_tdata.
//   Flow: the execute register loads at acceptance; the response register loads
//   from it when that register is empty or being taken, and rsp_tvalid then rises.
//   Throughput: one item per cycle while rsp_tready stays high. Every cell compares
//   and shifts in the same cycle; the delete search ripples one OR gate per cell.
//   Reset clears the entry count and both handshake stages; entry contents
//   are not cleared and are never read before being written.
//   While a response waits with rsp_tready low, the response register holds, the
//   execute stage holds its item, and req_tready drops once that stage is occupied.
module ordered_list_insert_delete #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] value, [36:32] position, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] entry_count, [36:5] read_value, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int VW    = olid_pkg::VALUE_W;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > olid_pkg::POS_W) ? CNT_W : olid_pkg::POS_W) + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   // execute stage
   logic                         ex_valid_ff, ex_valid_in;
   olid_pkg::mode_type           ex_mode_ff;
   logic [VW-1:0]                ex_value_ff;
   logic [olid_pkg::POS_W-1:0]   ex_pos_ff;
   logic                         exec_go;

   // list state
   logic [CNT_W-1:0]             count_ff, count_in;

   // response stage
   logic                         rsp_valid_ff, rsp_valid_in;
   olid_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [olid_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [VW-1:0]                rsp_read_ff, rsp_read_in;

   logic [CMP_W-1:0]             cnt_ext, pos_ext, at, rd_pos, cnt_next;
   logic [VW-1:0]                entry_q [DEPTH];
   logic [DEPTH:0]               found;
   logic                         full, ins_beyond, rd_beyond, ok;
   olid_pkg::cell_cmd_type       cmd;

   assign exec_go     = ex_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !ex_valid_ff || exec_go;
   assign ex_valid_in = (req_tvalid && req_tready) || (ex_valid_ff && !exec_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ex_mode_ff  <= olid_pkg::mode_type'(req_tuser);
         ex_value_ff <= req_tdata[31:0];
         ex_pos_ff   <= req_tdata[36:32];
      end
   end

   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_ext    = CMP_W'(ex_pos_ff);
   assign full       = (cnt_ext == DEPTH_C);
   assign ins_beyond = (pos_ext > cnt_ext + CMP_W'(1));
   assign rd_beyond  = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign at         = (pos_ext <= CMP_W'(1)) ? '0 : pos_ext - CMP_W'(1);
   assign rd_pos     = pos_ext - CMP_W'(1);

   always_comb begin
      rsp_status_in = olid_pkg::ST_OK;
      rsp_read_in   = '0;
      case (ex_mode_ff)
         olid_pkg::MODE_APPEND: begin
            if (full) rsp_status_in = olid_pkg::ST_FULL;
         end
         olid_pkg::MODE_INSERT: begin
            if (ins_beyond)  rsp_status_in = olid_pkg::ST_BEYOND;
            else if (full)   rsp_status_in = olid_pkg::ST_FULL;
         end
         olid_pkg::MODE_DELETE: begin
            if (!found[DEPTH]) rsp_status_in = olid_pkg::ST_MISSING;
         end
         olid_pkg::MODE_READ: begin
            if (rd_beyond) rsp_status_in = olid_pkg::ST_BEYOND;
            else           rsp_read_in   = entry_q[rd_pos[IDX_W-1:0]];
         end
         default: rsp_status_in = olid_pkg::ST_OK;
      endcase
   end

   assign ok = exec_go && (rsp_status_in == olid_pkg::ST_OK);

   always_comb begin
      cmd.append_en = ok && (ex_mode_ff == olid_pkg::MODE_APPEND);
      cmd.insert_en = ok && (ex_mode_ff == olid_pkg::MODE_INSERT);
      cmd.delete_en = ok && (ex_mode_ff == olid_pkg::MODE_DELETE);
      cmd.value     = ex_value_ff;
   end

   always_comb begin
      cnt_next = cnt_ext;
      if (cmd.append_en || cmd.insert_en) cnt_next = cnt_ext + CMP_W'(1);
      else if (cmd.delete_en)             cnt_next = cnt_ext - CMP_W'(1);
   end

   assign count_in     = cnt_next[CNT_W-1:0];
   assign rsp_count_in = cnt_next[olid_pkg::COUNT_W-1:0];
   assign rsp_valid_in = exec_go || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_read_ff   <= rsp_read_in;
      end
   end

   assign found[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VW-1:0] left_d, right_d;
      if (i == 0) begin : g_head
         assign left_d = entry_q[i];
      end else begin : g_mid
         assign left_d = entry_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_d = entry_q[i];
      end else begin : g_body
         assign right_d = entry_q[i+1];
      end
      olid_cell #(
         .CMP_W (CMP_W),
         .IDX   (i)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .count_i (cnt_ext),
         .at_i    (at),
         .left_i  (left_d),
         .right_i (right_d),
         .found_i (found[i]),
         .found_o (found[i+1]),
         .entry_o (entry_q[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_read_ff, rsp_count_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= DEPTH_C)
      else $error("entry count above depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.append_en |=> CMP_W'(count_ff) == $past(cnt_ext) + CMP_W'(1))
      else $error("append did not grow the list");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      exec_go && rsp_status_in == olid_pkg::ST_FULL |-> full)
      else $error("full status while list has room");

   a_delete_found: assert property (@(posedge clock) disable iff (reset)
      cmd.delete_en |-> cnt_ext != '0)
      else $error("delete on empty list");

endmodule
